/* rtl/core/lruwb_pkg.sv */
// Shared types and constants for the LRU write-back page cache.
// No dependencies; used by lruwb_cell and lru_writeback_page_cache.
package lruwb_pkg;

    localparam int ENTRIES_DEF      = 64;
    localparam int PAGE_BITS_DEF    = 64;
    localparam int ADDRESS_BITS_DEF = 40;
    localparam int OP_W             = 3;

    localparam logic [OP_W-1:0] OP_CONTAINS    = 3'd0;
    localparam logic [OP_W-1:0] OP_GET         = 3'd1;
    localparam logic [OP_W-1:0] OP_PUT         = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK_DIRTY  = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH       = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR_FLUSH = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_FINAL
    } state_t;

    // Per-cell load controls driven by the sequencer.
    typedef struct packed {
        logic cmp;        // capture tag match against the incoming address
        logic shift;      // load from the more recent neighbor
        logic rot;        // load from the less recent neighbor (flush walk)
        logic set_dirty;  // mark the held page dirty
        logic clear;      // invalidate the cell
    } cell_ctrl_t;

endpackage

/* rtl/core/lru_writeback_page_cache.sv */
// Fully associative page cache built as a chain of slots ordered by recency, slot 0 most
// recent. For a lookup the tags are compared in the accept cycle and the chain shifts in the
// next one unless the result side stalls; no new item is taken until the lookup is done.
// Flush and clear-and-flush rotate the whole chain once, one slot per cycle while no
// write-back is stalled on the result side.
// Depends on lruwb_pkg and lruwb_cell.
module lru_writeback_page_cache #(
    parameter int ENTRIES      = lruwb_pkg::ENTRIES_DEF,
    parameter int PAGE_BITS    = lruwb_pkg::PAGE_BITS_DEF,
    parameter int ADDRESS_BITS = lruwb_pkg::ADDRESS_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [lruwb_pkg::OP_W-1:0]   opcode,
    input  logic [ADDRESS_BITS-1:0]      page_address,
    input  logic [PAGE_BITS-1:0]         page_data,
    input  logic                         dirty_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic [PAGE_BITS-1:0]         read_data,
    output logic                         writeback_valid,
    output logic [ADDRESS_BITS-1:0]      writeback_address,
    output logic [PAGE_BITS-1:0]         writeback_data,
    output logic                         last
);

    localparam int STEP_W = $clog2(ENTRIES);

    lruwb_pkg::state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              emitted_reg, emitted_next;
    logic              wbe_reg;

    logic [lruwb_pkg::OP_W-1:0] op_reg;
    logic [ADDRESS_BITS-1:0]    addr_reg;
    logic [PAGE_BITS-1:0]       pdata_reg;
    logic                       din_reg;

    logic                    out_valid_reg, out_valid_next;
    logic                    hit_reg, hit_next;
    logic [PAGE_BITS-1:0]    rdata_reg, rdata_next;
    logic                    wbv_reg, wbv_next;
    logic [ADDRESS_BITS-1:0] wba_reg, wba_next;
    logic [PAGE_BITS-1:0]    wbd_reg, wbd_next;
    logic                    last_reg, last_next;

    lruwb_pkg::cell_ctrl_t   ctrl [ENTRIES];
    logic                    c_valid [ENTRIES];
    logic                    c_dirty [ENTRIES];
    logic [ADDRESS_BITS-1:0] c_tag   [ENTRIES];
    logic [PAGE_BITS-1:0]    c_data  [ENTRIES];
    logic [ENTRIES-1:0]      match_vec;
    logic [ENTRIES-1:0]      valid_vec;
    logic [ENTRIES-1:0]      above;

    logic                    any_hit, more_dirty;
    logic                    sel_dirty;
    logic [PAGE_BITS-1:0]    sel_data;
    logic                    head_dirty;
    logic [PAGE_BITS-1:0]    head_data;
    logic                    out_free, accept;
    logic                    exec_go, walk_go, final_go, emit_now, out_load;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == lruwb_pkg::S_IDLE);

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            logic                    pv, pd, nv, nd;
            logic [ADDRESS_BITS-1:0] pt, nt;
            logic [PAGE_BITS-1:0]    pdt, ndt;
            if (g == 0)
            begin : g_head
                assign pv  = 1'b1;
                assign pd  = head_dirty;
                assign pt  = addr_reg;
                assign pdt = head_data;
            end
            else
            begin : g_body
                assign pv  = c_valid[g-1];
                assign pd  = c_dirty[g-1];
                assign pt  = c_tag[g-1];
                assign pdt = c_data[g-1];
            end
            if (g == ENTRIES - 1)
            begin : g_wrap
                // The flush walk rotates slot 0 round to the tail, cleaned once written back.
                assign nv  = c_valid[0];
                assign nd  = c_dirty[0] && !wbe_reg;
                assign nt  = c_tag[0];
                assign ndt = c_data[0];
                assign above[g] = match_vec[g];
            end
            else
            begin : g_link
                assign nv  = c_valid[g+1];
                assign nd  = c_dirty[g+1];
                assign nt  = c_tag[g+1];
                assign ndt = c_data[g+1];
                assign above[g] = match_vec[g] || above[g+1];
            end
            lruwb_cell #(
                .PAGE_BITS    (PAGE_BITS),
                .ADDRESS_BITS (ADDRESS_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl[g]),
                .cmp_tag    (page_address),
                .prev_valid (pv),
                .prev_dirty (pd),
                .prev_tag   (pt),
                .prev_data  (pdt),
                .next_valid (nv),
                .next_dirty (nd),
                .next_tag   (nt),
                .next_data  (ndt),
                .valid      (c_valid[g]),
                .dirty      (c_dirty[g]),
                .tag        (c_tag[g]),
                .data       (c_data[g]),
                .match      (match_vec[g])
            );
            assign valid_vec[g] = c_valid[g];
        end
    endgenerate

    // At most one slot matches, so the selected page is an OR of the gated slots.
    always_comb
    begin
        sel_dirty  = 1'b0;
        sel_data   = '0;
        more_dirty = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            sel_dirty = sel_dirty | (match_vec[i] & c_dirty[i]);
            sel_data  = sel_data | (c_data[i] & {PAGE_BITS{match_vec[i]}});
            if (i > 0)
            begin
                more_dirty = more_dirty | (c_valid[i] & c_dirty[i]);
            end
        end
    end

    assign any_hit    = |match_vec;
    assign head_dirty = (op_reg == lruwb_pkg::OP_PUT) ? ((any_hit && sel_dirty) || din_reg)
                                                      : sel_dirty;
    assign head_data  = (op_reg == lruwb_pkg::OP_PUT) ? pdata_reg : sel_data;

    assign emit_now = wbe_reg && c_valid[0] && c_dirty[0];
    assign exec_go  = (state_reg == lruwb_pkg::S_EXEC) && out_free;
    assign walk_go  = (state_reg == lruwb_pkg::S_WALK) && (!emit_now || out_free);
    assign final_go = (state_reg == lruwb_pkg::S_FINAL) && (emitted_reg || out_free);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            ctrl[i].cmp       = accept;
            ctrl[i].shift     = exec_go &&
                                (((op_reg == lruwb_pkg::OP_GET || op_reg == lruwb_pkg::OP_PUT)
                                  && above[i]) ||
                                 (op_reg == lruwb_pkg::OP_PUT && !any_hit));
            ctrl[i].rot       = walk_go;
            ctrl[i].set_dirty = exec_go && (op_reg == lruwb_pkg::OP_MARK_DIRTY) && match_vec[i];
            ctrl[i].clear     = final_go && (op_reg == lruwb_pkg::OP_CLEAR_FLUSH);
        end
    end

    // Next state.
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        emitted_next = emitted_reg;
        case (state_reg)
            lruwb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    step_next    = '0;
                    emitted_next = 1'b0;
                    if (opcode == lruwb_pkg::OP_FLUSH || opcode == lruwb_pkg::OP_CLEAR_FLUSH)
                    begin
                        state_next = lruwb_pkg::S_WALK;
                    end
                    else
                    begin
                        state_next = lruwb_pkg::S_EXEC;
                    end
                end
            end
            lruwb_pkg::S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = lruwb_pkg::S_IDLE;
                end
            end
            lruwb_pkg::S_WALK:
            begin
                if (walk_go)
                begin
                    step_next    = step_reg + 1'b1;
                    emitted_next = emitted_reg || emit_now;
                    if (step_reg == STEP_W'(ENTRIES - 1))
                    begin
                        state_next = lruwb_pkg::S_FINAL;
                    end
                end
            end
            lruwb_pkg::S_FINAL:
            begin
                if (final_go)
                begin
                    state_next = lruwb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lruwb_pkg::S_IDLE;
            end
        endcase
    end

    // Result register loads.
    always_comb
    begin
        out_load   = 1'b0;
        hit_next   = 1'b0;
        rdata_next = '0;
        wbv_next   = 1'b0;
        wba_next   = '0;
        wbd_next   = '0;
        last_next  = 1'b1;
        case (state_reg)
            lruwb_pkg::S_EXEC:
            begin
                out_load = exec_go;
                if (op_reg <= lruwb_pkg::OP_MARK_DIRTY)
                begin
                    hit_next = any_hit;
                end
                if (op_reg == lruwb_pkg::OP_GET && any_hit)
                begin
                    rdata_next = sel_data;
                end
                if (op_reg == lruwb_pkg::OP_PUT && !any_hit && wbe_reg &&
                    c_valid[ENTRIES-1] && c_dirty[ENTRIES-1])
                begin
                    wbv_next = 1'b1;
                    wba_next = c_tag[ENTRIES-1];
                    wbd_next = c_data[ENTRIES-1];
                end
            end
            lruwb_pkg::S_WALK:
            begin
                out_load  = walk_go && emit_now;
                wbv_next  = 1'b1;
                wba_next  = c_tag[0];
                wbd_next  = c_data[0];
                last_next = !more_dirty;
            end
            lruwb_pkg::S_FINAL:
            begin
                out_load = final_go && !emitted_reg;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lruwb_pkg::S_IDLE;
            step_reg      <= '0;
            emitted_reg   <= 1'b0;
            wbe_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                wbe_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode;
            addr_reg  <= page_address;
            pdata_reg <= page_data;
            din_reg   <= dirty_in;
        end
        if (out_load)
        begin
            hit_reg   <= hit_next;
            rdata_reg <= rdata_next;
            wbv_reg   <= wbv_next;
            wba_reg   <= wba_next;
            wbd_reg   <= wbd_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign hit               = hit_reg;
    assign read_data         = rdata_reg;
    assign writeback_valid   = wbv_reg;
    assign writeback_address = wba_reg;
    assign writeback_data    = wbd_reg;
    assign last              = last_reg;

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lruwb_pkg::S_EXEC) |-> $onehot0(match_vec))
        else $error("more than one slot matches the address");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (final_go && op_reg == lruwb_pkg::OP_CLEAR_FLUSH) |=> (valid_vec == '0))
        else $error("slots still valid after clear and flush");

    a_walk_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lruwb_pkg::S_WALK && out_load) |-> wbe_reg)
        else $error("flush wrote back a page with write-back disabled");

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lruwb_pkg::S_IDLE && valid_vec[ENTRIES-1]) |-> valid_vec[0])
        else $error("recency chain lost its valid prefix");

endmodule

/* rtl/core/lruwb_cell.sv */
// One recency slot of the page cache chain: tag, page word, valid, dirty and match flag.
// Depends on lruwb_pkg for the cell control struct.
module lruwb_cell #(
    parameter int PAGE_BITS    = lruwb_pkg::PAGE_BITS_DEF,
    parameter int ADDRESS_BITS = lruwb_pkg::ADDRESS_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lruwb_pkg::cell_ctrl_t   ctrl,
    input  logic [ADDRESS_BITS-1:0] cmp_tag,
    input  logic                    prev_valid,
    input  logic                    prev_dirty,
    input  logic [ADDRESS_BITS-1:0] prev_tag,
    input  logic [PAGE_BITS-1:0]    prev_data,
    input  logic                    next_valid,
    input  logic                    next_dirty,
    input  logic [ADDRESS_BITS-1:0] next_tag,
    input  logic [PAGE_BITS-1:0]    next_data,
    output logic                    valid,
    output logic                    dirty,
    output logic [ADDRESS_BITS-1:0] tag,
    output logic [PAGE_BITS-1:0]    data,
    output logic                    match
);

    logic                    valid_reg, valid_next;
    logic                    dirty_reg, dirty_next;
    logic                    match_reg, match_next;
    logic [ADDRESS_BITS-1:0] tag_reg, tag_next;
    logic [PAGE_BITS-1:0]    data_reg, data_next;

    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        tag_next   = tag_reg;
        data_next  = data_reg;
        if (ctrl.shift)
        begin
            valid_next = prev_valid;
            dirty_next = prev_dirty;
            tag_next   = prev_tag;
            data_next  = prev_data;
        end
        else if (ctrl.rot)
        begin
            valid_next = next_valid;
            dirty_next = next_dirty;
            tag_next   = next_tag;
            data_next  = next_data;
        end
        if (ctrl.set_dirty)
        begin
            dirty_next = 1'b1;
        end
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
            dirty_next = 1'b0;
        end
        match_next = ctrl.cmp ? (valid_reg && (tag_reg == cmp_tag)) : match_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign dirty = dirty_reg;
    assign tag   = tag_reg;
    assign data  = data_reg;
    assign match = match_reg;

endmodule

/* test/page_cache_checker.sv */
// Checker for the LRU write-back page cache: watches both channels and the config port,
// keeps its own copy of the cache state and compares every result transfer in order.
// Depends on lruwb_pkg.
`timescale 1ns / 1ps

module page_cache_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [lruwb_pkg::OP_W-1:0] opcode,
    input  logic [39:0]                page_address,
    input  logic [63:0]                page_data,
    input  logic                       dirty_in,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       hit,
    input  logic [63:0]                read_data,
    input  logic                       writeback_valid,
    input  logic [39:0]                writeback_address,
    input  logic [63:0]                writeback_data,
    input  logic                       last,
    output int                         errors,
    output int                         pending
);

    localparam int SLOTS = lruwb_pkg::ENTRIES_DEF;

    typedef struct packed {
        logic        hit;
        logic [63:0] read_data;
        logic        wb_valid;
        logic [39:0] wb_addr;
        logic [63:0] wb_data;
        logic        last;
    } cache_result_t;

    cache_result_t result_q[$];

    logic        wb_enable;
    logic        slot_valid [SLOTS];
    logic [39:0] slot_tag   [SLOTS];
    logic [63:0] slot_data  [SLOTS];
    logic        slot_dirty [SLOTS];
    int          slot_rank  [SLOTS];
    int          fill_count;

    assign pending = result_q.size();

    function automatic int lookup(logic [39:0] tag);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_tag[i] == tag)
                return i;
        return -1;
    endfunction

    // Pages are written back from most to least recent.
    task automatic flush_pages();
        cache_result_t r;
        int n;
        n = 0;
        if (wb_enable) begin
            for (int rank = 0; rank < fill_count; rank++)
                for (int i = 0; i < SLOTS; i++)
                    if (slot_valid[i] && slot_rank[i] == rank && slot_dirty[i]) begin
                        r = '0;
                        r.wb_valid = 1'b1;
                        r.wb_addr  = slot_tag[i];
                        r.wb_data  = slot_data[i];
                        slot_dirty[i] = 1'b0;
                        result_q.push_back(r);
                        n++;
                    end
        end
        if (n == 0)
            result_q.push_back('0);
        result_q[result_q.size() - 1].last = 1'b1;
    endtask

    task automatic predict_access(logic [lruwb_pkg::OP_W-1:0] op, logic [39:0] tag,
                                  logic [63:0] data, logic din);
        cache_result_t r;
        int s;
        int victim;
        int old_rank;
        r = '0;
        r.last = 1'b1;
        if (op == lruwb_pkg::OP_FLUSH) begin
            flush_pages();
            return;
        end
        if (op == lruwb_pkg::OP_CLEAR_FLUSH) begin
            flush_pages();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_dirty[i] = 1'b0;
                slot_rank[i]  = 0;
            end
            fill_count = 0;
            return;
        end
        if (op > lruwb_pkg::OP_CLEAR_FLUSH) begin
            result_q.push_back(r);
            return;
        end
        s = lookup(tag);
        r.hit = (s >= 0);
        if (op == lruwb_pkg::OP_GET && s >= 0) begin
            r.read_data = slot_data[s];
            old_rank = slot_rank[s];
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && slot_rank[i] < old_rank) slot_rank[i]++;
            slot_rank[s] = 0;
        end else if (op == lruwb_pkg::OP_MARK_DIRTY && s >= 0) begin
            slot_dirty[s] = 1'b1;
        end else if (op == lruwb_pkg::OP_PUT && s >= 0) begin
            slot_data[s]  = data;
            slot_dirty[s] = slot_dirty[s] | din;
            old_rank = slot_rank[s];
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && slot_rank[i] < old_rank) slot_rank[i]++;
            slot_rank[s] = 0;
        end else if (op == lruwb_pkg::OP_PUT) begin
            victim = -1;
            if (fill_count >= SLOTS) begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_valid[i] && slot_rank[i] == fill_count - 1) victim = i;
                if (victim < 0) victim = 0;
                if (slot_dirty[victim] && wb_enable) begin
                    r.wb_valid = 1'b1;
                    r.wb_addr  = slot_tag[victim];
                    r.wb_data  = slot_data[victim];
                end
                slot_valid[victim] = 1'b0;
                fill_count--;
            end else begin
                for (int i = 0; i < SLOTS && victim < 0; i++)
                    if (!slot_valid[i]) victim = i;
                if (victim < 0) victim = 0;
            end
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i]) slot_rank[i]++;
            slot_valid[victim] = 1'b1;
            slot_tag[victim]   = tag;
            slot_data[victim]  = data;
            slot_dirty[victim] = din;
            slot_rank[victim]  = 0;
            fill_count++;
        end
        result_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cache_result_t exp_r;
        if (!rst_n) begin
            wb_enable  = 1'b1;
            fill_count = 0;
            errors     = 0;
            result_q.delete();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_tag[i]   = '0;
                slot_data[i]  = '0;
                slot_dirty[i] = 1'b0;
                slot_rank[i]  = 0;
            end
        end else begin
            if (cfg_wr_en)
                wb_enable = cfg_wr_data;
            if (in_valid && in_ready)
                predict_access(opcode, page_address, page_data, dirty_in);
            if (out_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result transfer");
                    errors++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (hit !== exp_r.hit) begin
                        $error("hit: expected %0h, got %0h", exp_r.hit, hit);
                        errors++;
                    end
                    if (read_data !== exp_r.read_data) begin
                        $error("read_data: expected %h, got %h", exp_r.read_data, read_data);
                        errors++;
                    end
                    if (writeback_valid !== exp_r.wb_valid) begin
                        $error("writeback_valid: expected %0h, got %0h", exp_r.wb_valid,
                               writeback_valid);
                        errors++;
                    end
                    if (writeback_address !== exp_r.wb_addr) begin
                        $error("writeback_address: expected %h, got %h", exp_r.wb_addr,
                               writeback_address);
                        errors++;
                    end
                    if (writeback_data !== exp_r.wb_data) begin
                        $error("writeback_data: expected %h, got %h", exp_r.wb_data,
                               writeback_data);
                        errors++;
                    end
                    if (last !== exp_r.last) begin
                        $error("last: expected %0h, got %0h", exp_r.last, last);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

/* test/tb_top.sv */
// Top of the page cache testbench: clock, reset, stimulus and the verdict.
// Depends on lruwb_pkg, lru_writeback_page_cache and page_cache_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_LIMIT = 5000;
    localparam int POOL_SIZE  = 68;
    localparam int SETTLE     = lruwb_pkg::ENTRIES_DEF + 16;
    localparam int OP_BITS    = lruwb_pkg::OP_W;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_wr_data = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [OP_BITS-1:0] opcode = '0;
    logic [39:0]        page_address = '0;
    logic [63:0]        page_data = '0;
    logic               dirty_in = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b1;
    logic               hit;
    logic [63:0]        read_data;
    logic               writeback_valid;
    logic [39:0]        writeback_address;
    logic [63:0]        writeback_data;
    logic               last;
    int                 errors;
    int                 pending;

    int          gap_pct = 0;
    int          stall_pct = 0;
    int          idle_cycles = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_writebacks = 0;
    int          walk_ptr = 0;
    logic [39:0] addr_pool [POOL_SIZE];

    lru_writeback_page_cache dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .opcode            (opcode),
        .page_address      (page_address),
        .page_data         (page_data),
        .dirty_in          (dirty_in),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .hit               (hit),
        .read_data         (read_data),
        .writeback_valid   (writeback_valid),
        .writeback_address (writeback_address),
        .writeback_data    (writeback_data),
        .last              (last)
    );

    page_cache_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .opcode            (opcode),
        .page_address      (page_address),
        .page_data         (page_data),
        .dirty_in          (dirty_in),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .hit               (hit),
        .read_data         (read_data),
        .writeback_valid   (writeback_valid),
        .writeback_address (writeback_address),
        .writeback_data    (writeback_data),
        .last              (last),
        .errors            (errors),
        .pending           (pending)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= !(stall_pct > 0 && $urandom_range(0, 99) < stall_pct);
    end

    // Watchdog: counts cycles in which neither channel makes a transfer; also tallies results and write-backs.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready) begin
                n_results <= n_results + 1;
                if (writeback_valid) n_writebacks <= n_writebacks + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(logic [OP_BITS-1:0] op, logic [39:0] addr, logic [63:0] data,
                             logic din);
        while (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        page_address <= addr;
        page_data    <= data;
        dirty_in     <= din;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        n_items++;
    endtask

    // Holds the sender off until every result is in and the block has settled.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_wb_enable(logic value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_items(int count);
        int                 r;
        int                 a;
        logic [OP_BITS-1:0] op;
        logic [39:0]        addr;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)      op = lruwb_pkg::OP_PUT;
            else if (r < 65) op = lruwb_pkg::OP_GET;
            else if (r < 75) op = lruwb_pkg::OP_CONTAINS;
            else if (r < 85) op = lruwb_pkg::OP_MARK_DIRTY;
            else if (r < 92) op = lruwb_pkg::OP_FLUSH;
            else if (r < 95) op = lruwb_pkg::OP_CLEAR_FLUSH;
            else             op = OP_BITS'($urandom_range(6, 7));
            a = $urandom_range(0, 9);
            if (a == 0) begin
                addr = 40'({$urandom, $urandom});
            end else if (a < 5) begin
                // Cycling through more pages than slots forces steady eviction.
                addr = addr_pool[walk_ptr];
                walk_ptr = (walk_ptr + 1) % POOL_SIZE;
            end else begin
                addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            send_item(op, addr, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = 40'({$urandom, $urandom});
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: field extremes, every opcode, hits and misses.
        send_item(lruwb_pkg::OP_FLUSH, '0, '0, 1'b0);
        send_item(lruwb_pkg::OP_GET, '0, '0, 1'b0);
        send_item(lruwb_pkg::OP_PUT, '0, '1, 1'b1);
        send_item(lruwb_pkg::OP_PUT, '1, '0, 1'b0);
        send_item(lruwb_pkg::OP_CONTAINS, '1, '0, 1'b0);
        send_item(lruwb_pkg::OP_CONTAINS, 40'h5, '0, 1'b0);
        send_item(lruwb_pkg::OP_GET, '0, '0, 1'b0);
        send_item(lruwb_pkg::OP_MARK_DIRTY, '1, '0, 1'b0);
        send_item(lruwb_pkg::OP_MARK_DIRTY, 40'h77, '0, 1'b0);
        send_item(lruwb_pkg::OP_PUT, '0, 64'h0123_4567_89ab_cdef, 1'b0);
        send_item(lruwb_pkg::OP_GET, '1, '0, 1'b0);
        send_item(3'd6, '1, '1, 1'b1);
        send_item(3'd7, '0, '0, 1'b0);
        send_item(lruwb_pkg::OP_FLUSH, '0, '0, 1'b0);
        send_item(lruwb_pkg::OP_FLUSH, '0, '0, 1'b0);
        send_item(lruwb_pkg::OP_PUT, 40'h12, 64'h55, 1'b1);
        send_item(lruwb_pkg::OP_CLEAR_FLUSH, '0, '0, 1'b0);
        send_item(lruwb_pkg::OP_CONTAINS, 40'h12, '0, 1'b0);
        write_wb_enable(1'b0);
        send_item(lruwb_pkg::OP_PUT, 40'h9, '1, 1'b1);
        send_item(lruwb_pkg::OP_FLUSH, '0, '0, 1'b0);
        send_item(lruwb_pkg::OP_CLEAR_FLUSH, '0, '0, 1'b0);

        write_wb_enable(1'b1);
        random_items(72);
        gap_pct = 56;
        write_wb_enable(1'b0);
        random_items(72);
        gap_pct = 0;
        stall_pct = 56;
        write_wb_enable(1'b1);
        random_items(72);
        gap_pct = 14;
        stall_pct = 14;
        random_items(36);
        drain();
        random_items(36);

        drain();
        $display("Covered %0d items and %0d results, %0d of them write-backs,", n_items,
                 n_results, n_writebacks);
        $display("with write-back on and off and four idling patterns.");
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
